[sv/cbt_pkg.sv]
// Shared types and codes for the Cyrillic byte transcoder.
package cbt_pkg;

  localparam logic [1:0] MODE_UTF8_TO_866  = 2'd0;
  localparam logic [1:0] MODE_1251_TO_866  = 2'd1;
  localparam logic [1:0] MODE_866_PASS     = 2'd2;
  localparam logic [1:0] MODE_866_TO_1251  = 2'd3;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_TRUNCATED  = 2'd1;
  localparam logic [1:0] STATUS_BAD_LEAD   = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       end_mark;
  } out_item_t;

endpackage

[sv/cyrillic_byte_transcoder_core.sv]
// Cyrillic byte transcoder: UTF-8/CP1251/CP866 conversion, one byte per item.
// Datapath: an accepted item passes through the input register, then the
//   result register.
// Throughput: one item per cycle; a stalled result holds one more item in
//   the input register before in_stall rises.
// Reset (synchronous): mode returns to UTF-8 to CP866, decoder state cleared.
module cyrillic_byte_transcoder_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  cbt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output cbt_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_wdata
);

  function automatic logic [7:0] map_code(input logic [15:0] cp);
    logic [15:0] d;
    begin
      d = 16'd0;
      if (cp == 16'h0401) begin
        map_code = 8'hF0;
      end else if (cp == 16'h0451) begin
        map_code = 8'hF1;
      end else if (cp >= 16'd1040 && cp <= 16'd1103) begin
        if (cp > 16'h043F) d = cp - 16'd864;
        else d = cp - 16'd912;
        map_code = d[7:0];
      end else begin
        map_code = cp[7:0];
      end
    end
  endfunction

  function automatic logic [7:0] from_1251(input logic [7:0] c);
    begin
      if (c >= 8'd240) from_1251 = c - 8'd16;
      else if (c >= 8'd192) from_1251 = c - 8'd64;
      else from_1251 = c;
    end
  endfunction

  function automatic logic [7:0] to_1251(input logic [7:0] c);
    begin
      if (c >= 8'd128 && c <= 8'd175) to_1251 = c + 8'd64;
      else if (c >= 8'd224 && c <= 8'd239) to_1251 = c + 8'd16;
      else to_1251 = c;
    end
  endfunction

  logic [1:0]         mode;
  logic               in_q_valid;
  cbt_pkg::in_item_t  in_q;
  logic [15:0]        code_accum, code_accum_next;
  logic [1:0]         bytes_pending, bytes_pending_next;
  logic               error_seen, error_seen_next;
  logic               advance, process, emit;
  logic [7:0]         ob;
  logic [1:0]         st;
  logic [15:0]        cp;

  assign advance  = !(out_valid && out_stall);
  assign process  = in_q_valid && advance;
  assign in_stall = in_q_valid && !advance;

  always_comb begin
    emit               = 1'b0;
    ob                 = 8'd0;
    st                 = cbt_pkg::STATUS_OK;
    code_accum_next    = code_accum;
    bytes_pending_next = bytes_pending;
    error_seen_next    = error_seen;
    cp                 = code_accum | {10'd0, in_q.in_byte[5:0]};
    if (!error_seen) begin
      unique case (mode)
        cbt_pkg::MODE_1251_TO_866: begin
          ob   = from_1251(in_q.in_byte);
          emit = 1'b1;
        end
        cbt_pkg::MODE_866_PASS: begin
          ob   = in_q.in_byte;
          emit = 1'b1;
        end
        cbt_pkg::MODE_866_TO_1251: begin
          ob   = to_1251(in_q.in_byte);
          emit = 1'b1;
        end
        default: begin
          if (bytes_pending == 2'd0) begin
            if (!in_q.in_byte[7]) begin
              ob   = in_q.in_byte;
              emit = 1'b1;
            end else if (in_q.in_byte[7:5] == 3'b110) begin
              code_accum_next    = {5'd0, in_q.in_byte[4:0], 6'd0};
              bytes_pending_next = 2'd1;
              if (in_q.is_last) begin
                st   = cbt_pkg::STATUS_TRUNCATED;
                emit = 1'b1;
              end
            end else if (in_q.in_byte[7:4] == 4'b1110) begin
              code_accum_next    = {in_q.in_byte[3:0], 12'd0};
              bytes_pending_next = 2'd2;
              if (in_q.is_last) begin
                st   = cbt_pkg::STATUS_TRUNCATED;
                emit = 1'b1;
              end
            end else begin
              st   = cbt_pkg::STATUS_BAD_LEAD;
              emit = 1'b1;
            end
          end else if (bytes_pending == 2'd2) begin
            code_accum_next    = code_accum | {4'd0, in_q.in_byte[5:0], 6'd0};
            bytes_pending_next = 2'd1;
            if (in_q.is_last) begin
              st   = cbt_pkg::STATUS_TRUNCATED;
              emit = 1'b1;
            end
          end else begin
            ob                 = map_code(cp);
            code_accum_next    = 16'd0;
            bytes_pending_next = 2'd0;
            emit               = 1'b1;
          end
        end
      endcase
      if (st != cbt_pkg::STATUS_OK) begin
        ob                 = 8'd0;
        code_accum_next    = 16'd0;
        bytes_pending_next = 2'd0;
        error_seen_next    = 1'b1;
      end
    end
    if (in_q.is_last) begin
      code_accum_next    = 16'd0;
      bytes_pending_next = 2'd0;
      error_seen_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= cbt_pkg::MODE_UTF8_TO_866;
      in_q_valid    <= 1'b0;
      out_valid     <= 1'b0;
      code_accum    <= 16'd0;
      bytes_pending <= 2'd0;
      error_seen    <= 1'b0;
    end else begin
      if (cfg_we) mode <= cfg_wdata;
      if (in_valid && !in_stall) in_q_valid <= 1'b1;
      else if (advance) in_q_valid <= 1'b0;
      if (advance) out_valid <= process && emit;
      if (process) begin
        code_accum    <= code_accum_next;
        bytes_pending <= bytes_pending_next;
        error_seen    <= error_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_q <= in_data;
    if (advance) begin
      out_data.out_byte <= ob;
      out_data.status   <= st;
      out_data.end_mark <= in_q.is_last;
    end
  end

endmodule

[sv/cbt_checker.sv]
// Port-level checks for the Cyrillic byte transcoder, bound to the top level.
module cbt_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input cbt_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != cbt_pkg::STATUS_OK |-> out_data.out_byte == 8'd0)
    else $error("error result carries a nonzero byte");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status == cbt_pkg::STATUS_OK ||
      out_data.status == cbt_pkg::STATUS_TRUNCATED ||
      out_data.status == cbt_pkg::STATUS_BAD_LEAD)
    else $error("undefined status code");

endmodule

bind cyrillic_byte_transcoder_core cbt_checker u_cbt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
